// File: design/linear_probe_key_table_core_assert.svh
// Assertion macros for the linear probe key table core.
`ifndef LINEAR_PROBE_KEY_TABLE_CORE_ASSERT_SVH
`define LINEAR_PROBE_KEY_TABLE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the core clock, off during reset.
`define LPKT_CHECK(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lpkt check failed");

// Next-cycle implication.
`define LPKT_CHECK_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lpkt check failed");

`endif

// File: design/lpkt_pkg.sv
// Shared types and constants for the linear probe key table.
package lpkt_pkg;

   localparam int TABLE_SIZE = 1024;
   localparam int SLOT_W     = $clog2(TABLE_SIZE);
   localparam int ENTRY_W    = SLOT_W + 1;
   localparam int KEY_W      = 64;
   localparam int TICK_W     = 31;
   localparam int STATUS_W   = 2;

   localparam logic [STATUS_W-1:0] STATUS_FOUND     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_INSERTED  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd3;

   typedef struct packed {
      logic [KEY_W-1:0]  key_word0;
      logic [KEY_W-1:0]  key_word1;
      logic [KEY_W-1:0]  key_word2;
      logic [KEY_W-1:0]  key_word3;
      logic [TICK_W-1:0] add_flag;
      logic [TICK_W-1:0] current_tick;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
      logic [ENTRY_W-1:0]  entry_number;
      logic [TICK_W-1:0]   entry_min_tick;
   } rsp_type;

   // One table row; ordinal zero marks an empty slot.
   typedef struct packed {
      logic [KEY_W-1:0]   key_word0;
      logic [KEY_W-1:0]   key_word1;
      logic [KEY_W-1:0]   key_word2;
      logic [KEY_W-1:0]   key_word3;
      logic [TICK_W-1:0]  min_tick;
      logic [ENTRY_W-1:0] ordinal;
   } entry_type;

   typedef struct packed {
      logic [SLOT_W-1:0] rd_addr;
      logic              wr_en;
      logic [SLOT_W-1:0] wr_addr;
      entry_type         wr_data;
   } mem_req_type;

endpackage

// File: design/linear_probe_key_table_core.sv
// Top level of the linear probe key table: sequencer, slot memory, result register.
// A request moves from IDLE through READ and EVAL in the sequencer; each further probe
//   repeats READ and EVAL, and the result waits in S_RESULT for the output register.
// One item at a time: req_ready stays low until the result has left S_RESULT,
//   and each probe step reads one slot and then compares its key.
// Reset: synchronous; a sweep then zeroes every slot's ordinal,
//   with req_ready low until it completes.
module linear_probe_key_table_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lpkt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lpkt_pkg::rsp_type rsp_data
);
   import lpkt_pkg::*;

   mem_req_type mem_req;
   entry_type   rd_data;
   logic        clear_busy;
   logic        res_valid;
   rsp_type     res_data;
   logic        res_free;
   logic        res_load;

   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   // Slot memory; holds off the sequencer while the post-reset sweep runs.
   lpkt_store u_store (
      .clock      (clock),
      .reset      (reset),
      .mem_req    (mem_req),
      .rd_data    (rd_data),
      .clear_busy (clear_busy)
   );

   // Probe sequencer: home slot, then linear walk with wraparound.
   lpkt_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .clear_busy (clear_busy),
      .mem_req    (mem_req),
      .rd_data    (rd_data),
      .res_valid  (res_valid),
      .res_data   (res_data),
      .res_free   (res_free)
   );

   // Output register: frees the sequencer to take the next item while a
   // finished result waits for its transfer.
   assign res_free = !rsp_valid_ff || rsp_ready;
   assign res_load = res_valid && res_free;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_data;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`include "linear_probe_key_table_core_assert.svh"

   // A pending result is never overwritten before its transfer.
   `LPKT_CHECK(a_no_overwrite, rsp_valid_ff && !rsp_ready, !res_load)
   // Once an item is taken the sequencer is busy on the next cycle.
   `LPKT_CHECK_NEXT(a_busy_after_take, req_valid && req_ready, !req_ready)
   // An inserted entry always carries a nonzero ordinal.
   `LPKT_CHECK(a_insert_ordinal, rsp_valid_ff && (rsp_data_ff.status == STATUS_INSERTED),
      rsp_data_ff.entry_number != '0)
   // A full table reports slot and ordinal as zero (the tick, also zero, is not checked).
   `LPKT_CHECK(a_full_zero, rsp_valid_ff && (rsp_data_ff.status == STATUS_FULL),
      (rsp_data_ff.slot == '0) && (rsp_data_ff.entry_number == '0))

endmodule

// File: design/lpkt_store.sv
// Slot memory with registered read and post-reset clearing sweep.
module lpkt_store (
   input  logic                clock,
   input  logic                reset,
   input  lpkt_pkg::mem_req_type mem_req,
   output lpkt_pkg::entry_type rd_data,
   output logic                clear_busy
);
   import lpkt_pkg::*;

   entry_type         mem [TABLE_SIZE];
   entry_type         rd_data_ff;
   logic              clear_busy_ff;
   logic [SLOT_W-1:0] clear_addr_ff;

   logic              wr_en;
   logic [SLOT_W-1:0] wr_addr;
   entry_type         wr_data;

   // Sweep owns the write port until every ordinal is zero.
   always_comb begin
      if (clear_busy_ff) begin
         wr_en   = 1'b1;
         wr_addr = clear_addr_ff;
         wr_data = '0;
      end else begin
         wr_en   = mem_req.wr_en;
         wr_addr = mem_req.wr_addr;
         wr_data = mem_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_busy_ff <= 1'b1;
         clear_addr_ff <= '0;
      end else if (clear_busy_ff) begin
         clear_addr_ff <= clear_addr_ff + 1'b1;
         if (clear_addr_ff == SLOT_W'(TABLE_SIZE - 1)) begin
            clear_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[mem_req.rd_addr];
   end

   assign rd_data    = rd_data_ff;
   assign clear_busy = clear_busy_ff;

endmodule

// File: design/lpkt_seq.sv
// Probe sequencer: one slot read and key compare per probe step.
module lpkt_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  lpkt_pkg::req_type     req_data,
   input  logic                  clear_busy,
   output lpkt_pkg::mem_req_type mem_req,
   input  lpkt_pkg::entry_type   rd_data,
   output logic                  res_valid,
   output lpkt_pkg::rsp_type     res_data,
   input  logic                  res_free
);
   import lpkt_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_EVAL,
      S_RESULT
   } state_type;

   state_type          state_ff, state_in;
   req_type            key_ff, key_in;
   logic               add_ff, add_in;
   logic [TICK_W-1:0]  tick_ff, tick_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [SLOT_W-1:0]  probe_ff, probe_in;
   logic [ENTRY_W-1:0] count_ff, count_in;
   rsp_type            res_ff, res_in;

   logic               key_hit;
   logic               slot_empty;
   logic [TICK_W-1:0]  raised_tick;
   logic [ENTRY_W-1:0] new_ordinal;

   assign key_hit = (rd_data.key_word0 == key_ff.key_word0) &&
                    (rd_data.key_word1 == key_ff.key_word1) &&
                    (rd_data.key_word2 == key_ff.key_word2) &&
                    (rd_data.key_word3 == key_ff.key_word3);
   assign slot_empty  = (rd_data.ordinal == '0);
   assign raised_tick = (tick_ff > rd_data.min_tick) ? tick_ff : rd_data.min_tick;
   assign new_ordinal = count_ff + 1'b1;

   always_comb begin
      state_in = state_ff;
      key_in   = key_ff;
      add_in   = add_ff;
      tick_in  = tick_ff;
      slot_in  = slot_ff;
      probe_in = probe_ff;
      count_in = count_ff;
      res_in   = res_ff;
      mem_req.rd_addr = slot_ff;
      mem_req.wr_en   = 1'b0;
      mem_req.wr_addr = slot_ff;
      mem_req.wr_data = rd_data;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && !clear_busy) begin
               key_in   = req_data;
               add_in   = (req_data.add_flag != '0);
               tick_in  = (req_data.add_flag == TICK_W'(1)) ? req_data.current_tick
                                                             : req_data.add_flag;
               slot_in  = SLOT_W'(req_data.key_word0[31:0] % TABLE_SIZE);
               probe_in = '0;
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (slot_empty) begin
               if (add_ff) begin
                  mem_req.wr_en             = 1'b1;
                  mem_req.wr_data.key_word0 = key_ff.key_word0;
                  mem_req.wr_data.key_word1 = key_ff.key_word1;
                  mem_req.wr_data.key_word2 = key_ff.key_word2;
                  mem_req.wr_data.key_word3 = key_ff.key_word3;
                  mem_req.wr_data.min_tick  = tick_ff;
                  mem_req.wr_data.ordinal   = new_ordinal;
                  count_in = new_ordinal;
                  res_in   = '{STATUS_INSERTED, slot_ff, new_ordinal, tick_ff};
               end else begin
                  res_in = '{STATUS_NOT_FOUND, slot_ff, '0, '0};
               end
               state_in = S_RESULT;
            end else if (key_hit) begin
               mem_req.wr_en            = 1'b1;
               mem_req.wr_data.min_tick = raised_tick;
               res_in   = '{STATUS_FOUND, slot_ff, rd_data.ordinal, raised_tick};
               state_in = S_RESULT;
            end else if (probe_ff == SLOT_W'(TABLE_SIZE - 1)) begin
               res_in   = '{STATUS_FULL, '0, '0, '0};
               state_in = S_RESULT;
            end else begin
               slot_in  = (slot_ff == SLOT_W'(TABLE_SIZE - 1)) ? '0 : slot_ff + 1'b1;
               probe_in = probe_ff + 1'b1;
               state_in = S_READ;
            end
         end
         S_RESULT: begin
            if (res_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      key_ff   <= key_in;
      add_ff   <= add_in;
      tick_ff  <= tick_in;
      slot_ff  <= slot_in;
      probe_ff <= probe_in;
      res_ff   <= res_in;
   end

   assign req_ready = (state_ff == S_IDLE) && !clear_busy;
   assign res_valid = (state_ff == S_RESULT);
   assign res_data  = res_ff;

endmodule

// File: verif/linear_probe_key_table_core_tb.sv
// Testbench for linear_probe_key_table_core: directed and random key traffic, scoreboard check.
`timescale 1ns / 100ps

module linear_probe_key_table_core_tb;

   import lpkt_pkg::*;

   // Stimulus sizing. The random part is long enough to fill every slot, so
   // the table-full case shows up near the end of the run.
   localparam int RANDOM_ITEMS   = 1730;
   localparam int QUIET_FIRST    = 300;   // no idling on either side from here ...
   localparam int QUIET_LAST     = 600;   // ... up to here
   localparam int DRAIN_AT       = 700;   // sender waits for all results here
   localparam int HOLD_AT_RESULT = 1000;  // receiver holds off after this many results
   localparam int HOLD_CYCLES    = 300;
   // A full-table miss probes every slot, and the reset sweep and the receiver
   // hold-off add idle time as well; the limit leaves plenty of margin.
   localparam int STALL_LIMIT    = 10000;
   localparam int MAX_REPORTS    = 10;

   // Mirror of the slot table. Computes the expected result of each transfer
   // and queues it until the block answers.
   class probe_table_model;
      entry_type rows [TABLE_SIZE];
      int unsigned entries;
      int unsigned errors;
      rsp_type awaiting [$];

      function new();
         foreach (rows[i]) rows[i].ordinal = '0;
         entries = 0;
         errors  = 0;
      endfunction

      function int pending();
         return awaiting.size();
      endfunction

      function void apply_request(req_type r);
         rsp_type want;
         logic [TICK_W-1:0] tick;
         int unsigned home;
         int unsigned s;
         bit settled;
         // flag of 1 means "use current tick"; any other value is the tick itself
         tick    = (r.add_flag == 1) ? r.current_tick : r.add_flag;
         home    = r.key_word0[31:0] % TABLE_SIZE;
         want    = '{status: STATUS_FULL, slot: '0, entry_number: '0, entry_min_tick: '0};
         settled = 1'b0;
         for (int i = 0; i < TABLE_SIZE && !settled; i++) begin
            s = (home + i) % TABLE_SIZE;
            if (rows[s].ordinal == 0) begin
               settled = 1'b1;
               if (r.add_flag == 0) begin
                  want = '{status: STATUS_NOT_FOUND, slot: SLOT_W'(s),
                           entry_number: '0, entry_min_tick: '0};
               end else begin
                  entries++;
                  rows[s] = '{key_word0: r.key_word0, key_word1: r.key_word1,
                              key_word2: r.key_word2, key_word3: r.key_word3,
                              min_tick: tick, ordinal: ENTRY_W'(entries)};
                  want = '{status: STATUS_INSERTED, slot: SLOT_W'(s),
                           entry_number: rows[s].ordinal, entry_min_tick: tick};
               end
            end else if (rows[s].key_word0 == r.key_word0 &&
                         rows[s].key_word1 == r.key_word1 &&
                         rows[s].key_word2 == r.key_word2 &&
                         rows[s].key_word3 == r.key_word3) begin
               settled = 1'b1;
               if (tick > rows[s].min_tick) rows[s].min_tick = tick;
               want = '{status: STATUS_FOUND, slot: SLOT_W'(s),
                        entry_number: rows[s].ordinal, entry_min_tick: rows[s].min_tick};
            end
         end
         awaiting.push_back(want);
      endfunction

      function void report(string what, rsp_type want, rsp_type got);
         errors++;
         if (errors <= MAX_REPORTS)
            $display("%s: want status %0d slot %0d entry %0d tick %0d, ",
                     what, want.status, want.slot, want.entry_number, want.entry_min_tick,
                     "got status %0d slot %0d entry %0d tick %0d",
                     got.status, got.slot, got.entry_number, got.entry_min_tick);
      endfunction

      function void compare_result(rsp_type got);
         rsp_type want;
         if (awaiting.size() == 0) begin
            report("unexpected result", '0, got);
            return;
         end
         want = awaiting.pop_front();
         if (got.status !== want.status || got.slot !== want.slot ||
             got.entry_number !== want.entry_number ||
             got.entry_min_tick !== want.entry_min_tick)
            report("result mismatch", want, got);
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   probe_table_model table_model = new();
   req_type key_pool [$];   // every key offered for insert, reused for hits and near misses
   bit      quiet;          // set by the sender: both sides stop idling

   linear_probe_key_table_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic req_type make_req(logic [63:0] w0, logic [63:0] w1, logic [63:0] w2,
                                        logic [63:0] w3, logic [30:0] flag, logic [30:0] tick);
      req_type r;
      r = '{key_word0: w0, key_word1: w1, key_word2: w2, key_word3: w3,
            add_flag: flag, current_tick: tick};
      return r;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Insert flag: half "use current tick", half an explicit tick, now and then the max.
   function automatic logic [30:0] insert_flag();
      logic [30:0] f;
      if ($urandom_range(1) == 0) return 31'd1;
      if ($urandom_range(19) == 0) return '1;
      f = 31'($urandom);
      return (f < 2) ? 31'd2 : f;
   endfunction

   // Random traffic. While slots remain, mostly fresh keys get inserted; once
   // the table is full, mostly known keys come back, and the few fresh ones
   // walk the whole table and report full.
   function automatic req_type next_random_item();
      req_type r;
      int unsigned reuse_pct;
      bit lookup;
      reuse_pct = (table_model.entries < TABLE_SIZE) ? 25 : 80;
      if (key_pool.size() != 0 && $urandom_range(99) < reuse_pct) begin
         r = key_pool[$urandom_range(key_pool.size() - 1)];
         lookup = ($urandom_range(99) < 30);
      end else begin
         if (key_pool.size() != 0 && $urandom_range(99) < 15) begin
            // near key: one bit off a known key, often the same home slot
            r = key_pool[$urandom_range(key_pool.size() - 1)];
            case ($urandom_range(3))
               0:       r.key_word0 ^= 64'd1 << $urandom_range(63);
               1:       r.key_word1 ^= 64'd1 << $urandom_range(63);
               2:       r.key_word2 ^= 64'd1 << $urandom_range(63);
               default: r.key_word3 ^= 64'd1 << $urandom_range(63);
            endcase
         end else begin
            r = make_req(rand64(), rand64(), rand64(), rand64(), '0, '0);
         end
         lookup = ($urandom_range(99) < 10);
         if (!lookup) key_pool.push_back(r);
      end
      r.add_flag     = lookup ? 31'd0 : insert_flag();
      r.current_tick = 31'($urandom);
      return r;
   endfunction

   // One transfer on the request side, with an occasional idle gap first.
   task automatic offer(input req_type item);
      if (!quiet && $urandom_range(99) < 10) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      table_model.apply_request(item);
   endtask

   // Stop offering until every expected result is back.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (table_model.pending() != 0);
   endtask

   // Main sequence: reset, directed items, random items, wind-down.
   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      quiet     = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Home slot 5: miss on the empty table, then insert with current tick at max.
      offer(make_req(64'h0000_0000_0000_0005, 64'h1, 64'h2, 64'h3, 31'd0, 31'h7FFF_FFFF));
      offer(make_req(64'h0000_0000_0000_0005, 64'h1, 64'h2, 64'h3, 31'd1, 31'h7FFF_FFFF));
      // Lookup hit leaves the tick alone; smaller explicit tick leaves it too.
      offer(make_req(64'h0000_0000_0000_0005, 64'h1, 64'h2, 64'h3, 31'd0, 31'd77));
      offer(make_req(64'h0000_0000_0000_0005, 64'h1, 64'h2, 64'h3, 31'd2, 31'd0));
      // Same home, key differs only in the top bit of the last word: probes to slot 6.
      offer(make_req(64'h0000_0000_0000_0005, 64'h1, 64'h2, 64'h8000_0000_0000_0003,
                     31'h7FFF_FFFF, 31'd0));
      // Same home, differs in word 1: slot 7, tick 0 through the current-tick path.
      offer(make_req(64'h0000_0000_0000_0005, 64'h3, 64'h2, 64'h3, 31'd1, 31'd0));
      // Re-insert raises the tick from 0.
      offer(make_req(64'h0000_0000_0000_0005, 64'h3, 64'h2, 64'h3, 31'd12345, 31'd9));
      // Lookup that walks past three occupied slots to an empty one.
      offer(make_req(64'h0000_0000_0000_0005, 64'h1, 64'hFFFF, 64'h3, 31'd0, 31'd0));
      // All-ones key lands on the last slot.
      offer(make_req('1, '1, '1, '1, 31'd1, 31'h5555_5555));
      // Same low hash bits, different upper word0 half: wraps around to slot 0.
      offer(make_req(64'h0000_0000_FFFF_FFFF, '1, '1, '1, 31'h7FFF_FFFF, 31'd0));
      // Lookup from the last slot wraps past slot 0 to an empty slot 1.
      offer(make_req(64'h1234_5678_FFFF_FFFF, '0, '0, '0, 31'd0, '1));
      // All-zero key: home 0 is taken, goes to slot 1.
      offer(make_req('0, '0, '0, '0, 31'd1, 31'h2AAA_AAAA));
      // Only the low 32 bits hash: 0x400 maps to slot 0 as well, lands in slot 2.
      offer(make_req(64'hFFFF_FFFF_0000_0400, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
                     64'hAAAA_AAAA_AAAA_AAAA, 31'h2AAA_AAAA, 31'h5555_5555));
      // Hits after wrap, and a tick of 0 that must not lower the stored one.
      offer(make_req('1, '1, '1, '1, 31'd0, 31'd0));
      offer(make_req('1, '1, '1, '1, 31'd1, 31'd0));
      offer(make_req(64'h0000_0000_FFFF_FFFF, '1, '1, '1, 31'd0, 31'd0));
      offer(make_req('0, '0, '0, '0, 31'h5555_5555, 31'd0));
      offer(make_req(64'hFFFF_FFFF_0000_0400, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
                     64'hAAAA_AAAA_AAAA_AAAA, 31'd0, 31'h7FFF_FFFF));
      drain();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         quiet = (n >= QUIET_FIRST && n < QUIET_LAST);
         if (n == DRAIN_AT) drain();
         offer(next_random_item());
      end
      drain();
      // nothing can be in flight once the last result is back; a short margin
      repeat (20) @(posedge clock);

      if (table_model.errors == 0) begin
         $display("linear_probe_key_table_core_tb: done, clean");
      end else begin
         $display("linear_probe_key_table_core_tb: done, errors");
      end
      $finish;
   end

   // Result side: check each transfer, idle at random, and hold off once for
   // a long stretch so the block backs up into its request port.
   initial begin
      int unsigned results_seen;
      int unsigned hold_left;
      results_seen = 0;
      hold_left    = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            table_model.compare_result(rsp_data);
            results_seen++;
            if (results_seen == HOLD_AT_RESULT) hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= (quiet || $urandom_range(99) >= 10);
         end
      end
   end

   // Watchdog: too many cycles without a transfer on either side ends the run.
   initial begin
      int unsigned idle_cycles;
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("linear_probe_key_table_core_tb: done, errors");
            $finish;
         end
      end
   end

endmodule

// File: filelist.f
+incdir+design
design/lpkt_pkg.sv
design/lpkt_store.sv
design/lpkt_seq.sv
design/linear_probe_key_table_core.sv
verif/linear_probe_key_table_core_tb.sv
